// ----- rtl/ufb_pkg.sv -----
// Types and constants shared by the Ethernet/IPv4/UDP frame builder.
package ufb_pkg;

  localparam int unsigned HDR_LEN   = 42;
  localparam int unsigned MIN_FRAME = 60;
  localparam int unsigned SUM_STEPS = 5;

  localparam logic [7:0]  IP_VER_IHL   = 8'h45;
  localparam logic [15:0] ETHERTYPE    = 16'h0800;
  localparam logic [15:0] IP_FLAGS_DF  = 16'h4000;
  localparam logic [7:0]  IP_TTL       = 8'd64;
  localparam logic [7:0]  IP_PROTO_UDP = 8'd17;
  localparam logic [15:0] IP_LEN_ADD   = 16'd28;
  localparam logic [15:0] UDP_LEN_ADD  = 16'd8;

  // Fixed IPv4 header words folded into the checksum before the variable ones.
  localparam logic [15:0] CSUM_SEED = {IP_VER_IHL, 8'h00} + IP_FLAGS_DF
                                    + {IP_TTL, IP_PROTO_UDP};

  typedef enum logic [0:0] {
    CMD_START = 1'b0,
    CMD_BYTE  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_TOO_LONG = 2'd1,
    STAT_NO_ROOM  = 2'd2,
    STAT_NO_FRAME = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    CFG_SRC_MAC   = 3'd0,
    CFG_DST_MAC   = 3'd1,
    CFG_SRC_IP    = 3'd2,
    CFG_DST_IP    = 3'd3,
    CFG_SRC_PORT  = 3'd4,
    CFG_DST_PORT  = 3'd5,
    CFG_FRAME_CAP = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [15:0] pay_len;
    logic [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
    status_e    status;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  index;
    logic [47:0] value;
  } cfg_wr_t;

  typedef struct packed {
    logic [47:0] src_mac;
    logic [47:0] dst_mac;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [15:0] frame_capacity;
  } cfg_t;

  typedef struct packed {
    logic        init;
    logic        add;
    logic [15:0] word;
  } csum_ctl_t;

endpackage

// ----- rtl/ufb_chan_if.sv -----
// Valid/ready channel carrying one payload struct per transaction.
interface ufb_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/ufb_cfg_regs.sv -----
// Configuration register bank of the frame builder.
module ufb_cfg_regs (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_vld_i,
  input  ufb_pkg::cfg_wr_t wr_i,
  output ufb_pkg::cfg_t  cfg_o
);

  ufb_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q                <= '0;
      cfg_q.frame_capacity <= 16'hFFFF;
    end else if (wr_vld_i) begin
      unique case (wr_i.index)
        ufb_pkg::CFG_SRC_MAC:   cfg_q.src_mac        <= wr_i.value;
        ufb_pkg::CFG_DST_MAC:   cfg_q.dst_mac        <= wr_i.value;
        ufb_pkg::CFG_SRC_IP:    cfg_q.src_ip         <= wr_i.value[31:0];
        ufb_pkg::CFG_DST_IP:    cfg_q.dst_ip         <= wr_i.value[31:0];
        ufb_pkg::CFG_SRC_PORT:  cfg_q.src_port       <= wr_i.value[15:0];
        ufb_pkg::CFG_DST_PORT:  cfg_q.dst_port       <= wr_i.value[15:0];
        ufb_pkg::CFG_FRAME_CAP: cfg_q.frame_capacity <= wr_i.value[15:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/ufb_csum.sv -----
// Ones-complement adder that builds the IPv4 header checksum one word a cycle.
module ufb_csum (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ufb_pkg::csum_ctl_t ctl_i,
  output logic [15:0]       csum_o
);

  logic [15:0] acc_q, acc_d;
  logic [16:0] sum;

  always_comb begin
    sum   = {1'b0, acc_q} + {1'b0, ctl_i.word};
    acc_d = acc_q;
    if (ctl_i.init) begin
      acc_d = ufb_pkg::CSUM_SEED;
    end else if (ctl_i.add) begin
      // end-around carry
      acc_d = sum[15:0] + {15'd0, sum[16]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  assign csum_o = ~acc_q;

endmodule

// ----- rtl/ufb_seq.sv -----
// Sequencer: start checks, checksum steps, header bytes, payload pass-through, padding.
module ufb_seq #(
  parameter int MAX_PAYLOAD = 1472
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ufb_pkg::cfg_t       cfg_i,
  input  logic                in_vld_i,
  input  ufb_pkg::in_item_t   in_data_i,
  output logic                in_rdy_o,
  output logic                out_vld_o,
  output ufb_pkg::out_item_t  out_data_o,
  input  logic                out_rdy_i,
  output ufb_pkg::csum_ctl_t  csum_ctl_o,
  input  logic [15:0]         csum_i
);

  localparam int PLW = $clog2(MAX_PAYLOAD + 2);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SUM,
    S_HDR,
    S_PAD
  } state_e;

  state_e             state_q;
  logic               out_vld_q;
  ufb_pkg::out_item_t out_q;
  logic               open_q;
  logic [PLW-1:0]     left_q;
  logic [PLW-1:0]     len_q;
  logic [4:0]         pad_q;
  logic [5:0]         idx_q;

  logic        ld_ok;
  logic        in_acc;
  logic        too_long;
  logic        no_room;
  logic [16:0] flen;
  logic [16:0] need;
  logic [4:0]  start_pad;
  logic [15:0] ip_len;
  logic [15:0] udp_len;
  logic [7:0]  hdr_byte;

  always_comb begin
    ld_ok     = !out_vld_q || out_rdy_i;
    in_rdy_o  = (state_q == S_IDLE) && ld_ok;
    in_acc    = in_vld_i && in_rdy_o;
    too_long  = in_data_i.pay_len > 16'(MAX_PAYLOAD);
    flen      = {1'b0, in_data_i.pay_len} + 17'(ufb_pkg::HDR_LEN);
    need      = (flen < 17'(ufb_pkg::MIN_FRAME)) ? 17'(ufb_pkg::MIN_FRAME) : flen;
    no_room   = {1'b0, cfg_i.frame_capacity} < need;
    start_pad = (flen < 17'(ufb_pkg::MIN_FRAME))
              ? 5'(ufb_pkg::MIN_FRAME - ufb_pkg::HDR_LEN) - in_data_i.pay_len[4:0]
              : 5'd0;
    ip_len    = 16'(len_q) + ufb_pkg::IP_LEN_ADD;
    udp_len   = 16'(len_q) + ufb_pkg::UDP_LEN_ADD;
  end

  // Checksum unit control: seed on an accepted start, then one word per step.
  always_comb begin
    csum_ctl_o.init = in_acc && (in_data_i.cmd == ufb_pkg::CMD_START) && !too_long && !no_room;
    csum_ctl_o.add  = (state_q == S_SUM);
    unique case (idx_q[2:0])
      3'd0:    csum_ctl_o.word = ip_len;
      3'd1:    csum_ctl_o.word = {cfg_i.src_ip[7:0],   cfg_i.src_ip[15:8]};
      3'd2:    csum_ctl_o.word = {cfg_i.src_ip[23:16], cfg_i.src_ip[31:24]};
      3'd3:    csum_ctl_o.word = {cfg_i.dst_ip[7:0],   cfg_i.dst_ip[15:8]};
      3'd4:    csum_ctl_o.word = {cfg_i.dst_ip[23:16], cfg_i.dst_ip[31:24]};
      default: csum_ctl_o.word = 16'd0;
    endcase
  end

  always_comb begin
    unique case (idx_q)
      6'd0:    hdr_byte = cfg_i.dst_mac[47:40];
      6'd1:    hdr_byte = cfg_i.dst_mac[39:32];
      6'd2:    hdr_byte = cfg_i.dst_mac[31:24];
      6'd3:    hdr_byte = cfg_i.dst_mac[23:16];
      6'd4:    hdr_byte = cfg_i.dst_mac[15:8];
      6'd5:    hdr_byte = cfg_i.dst_mac[7:0];
      6'd6:    hdr_byte = cfg_i.src_mac[47:40];
      6'd7:    hdr_byte = cfg_i.src_mac[39:32];
      6'd8:    hdr_byte = cfg_i.src_mac[31:24];
      6'd9:    hdr_byte = cfg_i.src_mac[23:16];
      6'd10:   hdr_byte = cfg_i.src_mac[15:8];
      6'd11:   hdr_byte = cfg_i.src_mac[7:0];
      6'd12:   hdr_byte = ufb_pkg::ETHERTYPE[15:8];
      6'd13:   hdr_byte = ufb_pkg::ETHERTYPE[7:0];
      6'd14:   hdr_byte = ufb_pkg::IP_VER_IHL;
      6'd15:   hdr_byte = 8'h00;
      6'd16:   hdr_byte = ip_len[15:8];
      6'd17:   hdr_byte = ip_len[7:0];
      6'd18:   hdr_byte = 8'h00;
      6'd19:   hdr_byte = 8'h00;
      6'd20:   hdr_byte = ufb_pkg::IP_FLAGS_DF[15:8];
      6'd21:   hdr_byte = ufb_pkg::IP_FLAGS_DF[7:0];
      6'd22:   hdr_byte = ufb_pkg::IP_TTL;
      6'd23:   hdr_byte = ufb_pkg::IP_PROTO_UDP;
      6'd24:   hdr_byte = csum_i[15:8];
      6'd25:   hdr_byte = csum_i[7:0];
      6'd26:   hdr_byte = cfg_i.src_ip[7:0];
      6'd27:   hdr_byte = cfg_i.src_ip[15:8];
      6'd28:   hdr_byte = cfg_i.src_ip[23:16];
      6'd29:   hdr_byte = cfg_i.src_ip[31:24];
      6'd30:   hdr_byte = cfg_i.dst_ip[7:0];
      6'd31:   hdr_byte = cfg_i.dst_ip[15:8];
      6'd32:   hdr_byte = cfg_i.dst_ip[23:16];
      6'd33:   hdr_byte = cfg_i.dst_ip[31:24];
      6'd34:   hdr_byte = cfg_i.src_port[7:0];
      6'd35:   hdr_byte = cfg_i.src_port[15:8];
      6'd36:   hdr_byte = cfg_i.dst_port[7:0];
      6'd37:   hdr_byte = cfg_i.dst_port[15:8];
      6'd38:   hdr_byte = udp_len[15:8];
      6'd39:   hdr_byte = udp_len[7:0];
      default: hdr_byte = 8'h00;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
      out_q     <= '0;
      open_q    <= 1'b0;
      left_q    <= '0;
      len_q     <= '0;
      pad_q     <= '0;
      idx_q     <= '0;
    end else begin
      if (out_vld_q && out_rdy_i) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            out_vld_q <= 1'b1;
            if (in_data_i.cmd == ufb_pkg::CMD_BYTE) begin
              if (!open_q) begin
                out_q <= '{8'h00, 1'b1, ufb_pkg::STAT_NO_FRAME};
              end else begin
                left_q <= left_q - PLW'(1);
                out_q  <= '{in_data_i.data_byte,
                            (left_q == PLW'(1)) && (pad_q == 5'd0), ufb_pkg::STAT_OK};
                if (left_q == PLW'(1)) begin
                  open_q <= 1'b0;
                  if (pad_q != 5'd0) begin
                    state_q <= S_PAD;
                  end
                end
              end
            end else begin
              // A start drops any open frame.
              open_q <= 1'b0;
              left_q <= '0;
              pad_q  <= '0;
              if (too_long) begin
                out_q <= '{8'h00, 1'b1, ufb_pkg::STAT_TOO_LONG};
              end else if (no_room) begin
                out_q <= '{8'h00, 1'b1, ufb_pkg::STAT_NO_ROOM};
              end else begin
                out_vld_q <= out_vld_q && !out_rdy_i;
                len_q     <= in_data_i.pay_len[PLW-1:0];
                pad_q     <= start_pad;
                idx_q     <= '0;
                state_q   <= S_SUM;
              end
            end
          end
        end
        S_SUM: begin
          idx_q <= idx_q + 6'd1;
          if (idx_q == 6'(ufb_pkg::SUM_STEPS - 1)) begin
            idx_q   <= '0;
            state_q <= S_HDR;
          end
        end
        S_HDR: begin
          if (ld_ok) begin
            out_vld_q <= 1'b1;
            out_q     <= '{hdr_byte, 1'b0, ufb_pkg::STAT_OK};
            idx_q     <= idx_q + 6'd1;
            if (idx_q == 6'(ufb_pkg::HDR_LEN - 1)) begin
              if (len_q == '0) begin
                state_q <= S_PAD;
              end else begin
                open_q  <= 1'b1;
                left_q  <= len_q;
                state_q <= S_IDLE;
              end
            end
          end
        end
        S_PAD: begin
          if (ld_ok) begin
            out_vld_q <= 1'b1;
            out_q     <= '{8'h00, pad_q == 5'd1, ufb_pkg::STAT_OK};
            pad_q     <= pad_q - 5'd1;
            if (pad_q == 5'd1) begin
              state_q <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_vld_o  = out_vld_q;
  assign out_data_o = out_q;

endmodule

// ----- rtl/udp_ipv4_ethernet_frame_builder.sv -----
// Top level of the Ethernet/IPv4/UDP frame builder.
//
//  channel  dir  payload                              transaction
//  in_i     in   cmd, pay_len, data_byte              start or one payload byte
//  out_o    out  out_byte, frame_end, status          one frame byte or error
//  cfg_i    in   index (3b), value (48b)              register write, always ready
//
// A start gets its length checks on acceptance, feeds five words through the checksum
// adder, then sends 42 header bytes at one per cycle, plus padding when the frame is
// under 60 bytes. Payload bytes and error results go out one per cycle through a single
// output register; pad bytes after the last payload byte follow one per cycle
// while input is held off. Output stalls hold the sequencer in place, but for the
// checksum steps. Reset is asynchronous and needs no clearing pass.
module udp_ipv4_ethernet_frame_builder #(
  parameter int MAX_PAYLOAD = 1472
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  ufb_chan_if.sink     in_i,
  ufb_chan_if.source   out_o,
  ufb_chan_if.sink     cfg_i
);

  ufb_pkg::cfg_t      cfg;
  ufb_pkg::csum_ctl_t csum_ctl;
  logic [15:0]        csum;
  logic               in_rdy;
  logic               out_vld;
  ufb_pkg::out_item_t out_data;

  assign cfg_i.ready = 1'b1;

  ufb_cfg_regs u_cfg_regs (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_vld_i (cfg_i.valid),
    .wr_i     (cfg_i.data),
    .cfg_o    (cfg)
  );

  ufb_csum u_csum (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (csum_ctl),
    .csum_o (csum)
  );

  ufb_seq #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_vld_i   (in_i.valid),
    .in_data_i  (in_i.data),
    .in_rdy_o   (in_rdy),
    .out_vld_o  (out_vld),
    .out_data_o (out_data),
    .out_rdy_i  (out_o.ready),
    .csum_ctl_o (csum_ctl),
    .csum_i     (csum)
  );

  assign in_i.ready  = in_rdy;
  assign out_o.valid = out_vld;
  assign out_o.data  = out_data;

endmodule

// ----- rtl/ufb_checker.sv -----
// Port-level assertions for the frame builder, bound to the top level.
module ufb_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input ufb_pkg::cmd_e      in_cmd_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input ufb_pkg::out_item_t out_data_i
);

  // A stalled output transaction holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("output changed while stalled");

  a_err_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_data_i.status != ufb_pkg::STAT_OK)
      |-> out_data_i.frame_end && (out_data_i.out_byte == 8'h00))
    else $error("error result without frame_end or with nonzero byte");

  a_byte_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_cmd_i == ufb_pkg::CMD_BYTE) |=> out_valid_i)
    else $error("payload byte produced no result");

  a_ready_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_i |-> !out_valid_i || out_ready_i)
    else $error("input ready while output register is blocked");

endmodule

bind udp_ipv4_ethernet_frame_builder ufb_checker u_ufb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_cmd_i    (in_i.data.cmd),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);
